### rtl/core/tpwc_pkg.sv
// Timecode packed word codec: shared types, status codes and field helpers.
// No dependencies.
package tpwc_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned UB_W    = 32;
  localparam int unsigned FRAME_W = 6;
  localparam int unsigned SEC_W   = 7;
  localparam int unsigned MIN_W   = 7;
  localparam int unsigned HOUR_W  = 6;
  localparam int unsigned VAL_W   = 7;

  localparam logic [VAL_W-1:0] HOUR_LIMIT      = 7'd24;
  localparam logic [VAL_W-1:0] MS_LIMIT        = 7'd60;
  localparam logic [VAL_W-1:0] FRAME_LIMIT_PAL  = 7'd25;
  localparam logic [VAL_W-1:0] FRAME_LIMIT_NTSC = 7'd30;

  localparam logic REQ_DECODE = 1'b0;
  localparam logic REQ_ENCODE = 1'b1;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_HMS   = 2'd1,
    STS_FRAME = 2'd2
  } sts_t;

  typedef struct packed {
    logic                 req_type;
    logic [WORD_W-1:0]    packed_word;
    logic [FRAME_W-1:0]   frame_in;
    logic [SEC_W-1:0]     second_in;
    logic [MIN_W-1:0]     minute_in;
    logic [HOUR_W-1:0]    hour_in;
    logic [UB_W-1:0]      user_bits_in;
    logic                 drop_in;
    logic                 color_in;
    logic                 odd_in;
    logic                 ntsc_in;
  } in_item_t;

  typedef struct packed {
    sts_t                 status;
    logic [WORD_W-1:0]    word_out;
    logic [FRAME_W-1:0]   frame_out;
    logic [SEC_W-1:0]     second_out;
    logic [MIN_W-1:0]     minute_out;
    logic [HOUR_W-1:0]    hour_out;
    logic [UB_W-1:0]      user_bits_out;
    logic                 drop_out;
    logic                 color_out;
    logic                 odd_out;
  } out_item_t;

  // tens * 10 + units
  function automatic logic [VAL_W-1:0] bcd_to_bin(input logic [2:0] tens,
                                                   input logic [3:0] units);
    logic [VAL_W-1:0] t;
    t = {4'd0, tens};
    return (t << 3) + (t << 1) + {3'd0, units};
  endfunction

  // Tens digit of a value below 80; larger values never reach the word.
  function automatic logic [2:0] tens_of(input logic [VAL_W-1:0] v);
    logic [2:0] t;
    priority if (v >= 7'd70) t = 3'd7;
    else if (v >= 7'd60) t = 3'd6;
    else if (v >= 7'd50) t = 3'd5;
    else if (v >= 7'd40) t = 3'd4;
    else if (v >= 7'd30) t = 3'd3;
    else if (v >= 7'd20) t = 3'd2;
    else if (v >= 7'd10) t = 3'd1;
    else t = 3'd0;
    return t;
  endfunction

  function automatic logic [3:0] units_of(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] r;
    r = v - bcd_to_bin(tens_of(v), 4'd0);
    return r[3:0];
  endfunction

  function automatic sts_t check_tc(input logic [VAL_W-1:0] hour,
                                    input logic [VAL_W-1:0] minute,
                                    input logic [VAL_W-1:0] second,
                                    input logic [VAL_W-1:0] frame,
                                    input logic drop,
                                    input logic ntsc);
    sts_t s;
    priority if (hour >= HOUR_LIMIT || minute >= MS_LIMIT || second >= MS_LIMIT)
      s = STS_HMS;
    else if (ntsc)
      s = (frame < FRAME_LIMIT_NTSC) ? STS_OK : STS_FRAME;
    else
      s = (frame < FRAME_LIMIT_PAL && !drop) ? STS_OK : STS_FRAME;
    return s;
  endfunction

endpackage

### rtl/core/tpwc_codec.sv
// Timecode packed word codec: combinational decode/encode of one item.
// Depends on tpwc_pkg.
module tpwc_codec (
  input  tpwc_pkg::in_item_t  item,
  input  logic                decode_ntsc,
  output tpwc_pkg::out_item_t res
);
  import tpwc_pkg::*;

  logic [WORD_W-1:0]  w;
  logic [VAL_W-1:0]   dec_fr, dec_se, dec_mi, dec_ho;
  logic [VAL_W-1:0]   enc_fr, enc_se, enc_mi, enc_ho;
  logic [2:0]         enc_fr_tens, enc_ho_tens;
  logic [UB_W-1:0]    ub;
  logic [WORD_W-1:0]  enc_word;
  sts_t               dec_sts, enc_sts;

  assign w = item.packed_word;

  assign dec_fr = bcd_to_bin({1'b0, w[9:8]},   w[3:0]);
  assign dec_se = bcd_to_bin(w[26:24],          w[19:16]);
  assign dec_mi = bcd_to_bin(w[42:40],          w[35:32]);
  assign dec_ho = bcd_to_bin({1'b0, w[57:56]}, w[51:48]);
  assign dec_sts = check_tc(dec_ho, dec_mi, dec_se, dec_fr, w[10], decode_ntsc);

  assign enc_fr = {1'b0, item.frame_in};
  assign enc_se = item.second_in;
  assign enc_mi = item.minute_in;
  assign enc_ho = {1'b0, item.hour_in};
  assign ub     = item.user_bits_in;
  assign enc_sts = check_tc(enc_ho, enc_mi, enc_se, enc_fr, item.drop_in, item.ntsc_in);

  assign enc_fr_tens = tens_of(enc_fr);
  assign enc_ho_tens = tens_of(enc_ho);

  always_comb begin
    enc_word = '0;
    enc_word[3:0]   = units_of(enc_fr);
    enc_word[9:8]   = enc_fr_tens[1:0];
    enc_word[10]    = item.drop_in;
    enc_word[11]    = item.color_in;
    enc_word[19:16] = units_of(enc_se);
    enc_word[26:24] = tens_of(enc_se);
    enc_word[27]    = item.odd_in;
    enc_word[35:32] = units_of(enc_mi);
    enc_word[42:40] = tens_of(enc_mi);
    enc_word[51:48] = units_of(enc_ho);
    enc_word[57:56] = enc_ho_tens[1:0];
    enc_word[7:4]   = ub[3:0];
    enc_word[15:12] = ub[7:4];
    enc_word[23:20] = ub[11:8];
    enc_word[31:28] = ub[15:12];
    enc_word[39:36] = ub[19:16];
    enc_word[47:44] = ub[23:20];
    enc_word[55:52] = ub[27:24];
    enc_word[63:60] = ub[31:28];
  end

  always_comb begin
    res = '0;
    if (item.req_type == REQ_ENCODE) begin
      res.status   = enc_sts;
      res.word_out = (enc_sts == STS_OK) ? enc_word : '0;
    end else begin
      res.status        = dec_sts;
      res.frame_out     = dec_fr[FRAME_W-1:0];
      res.second_out    = dec_se;
      res.minute_out    = dec_mi;
      res.hour_out      = dec_ho[HOUR_W-1:0];
      res.user_bits_out = {w[63:60], w[55:52], w[47:44], w[39:36],
                           w[31:28], w[23:20], w[15:12], w[7:4]};
      res.drop_out      = w[10];
      res.color_out     = w[11];
      res.odd_out       = w[27];
    end
  end

endmodule

### rtl/core/timecode_packed_word_codec.sv
// Timecode packed word codec, top level: input register, codec, result register.
// Depends on tpwc_pkg and tpwc_codec.
// Result strobed after the input and result registers; one item per cycle.
// busy is never raised; results cannot be stalled.
// Synchronous active-low reset clears the pipeline valids and the NTSC register.
module timecode_packed_word_codec (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tpwc_pkg::in_item_t  in_data,
  output logic                out_strobe,
  output tpwc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);
  import tpwc_pkg::*;

  logic      in_vld_r, out_vld_r, ntsc_r;
  in_item_t  in_r;
  out_item_t res_nxt, out_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      ntsc_r    <= 1'b0;
    end else begin
      in_vld_r  <= start && !busy;
      out_vld_r <= in_vld_r;
      if (cfg_we) begin
        ntsc_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
    if (in_vld_r) begin
      out_r <= res_nxt;
    end
  end

  tpwc_codec u_codec (
    .item        (in_r),
    .decode_ntsc (ntsc_r),
    .res         (res_nxt)
  );

  assign out_strobe = out_vld_r;
  assign out_data   = out_r;

endmodule

### rtl/core/tpwc_checker.sv
// Timecode packed word codec: port-level checks and bind to the top level.
// Depends on tpwc_pkg and timecode_packed_word_codec.
module tpwc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input tpwc_pkg::out_item_t out_data,
  input logic                out_strobe
);
  import tpwc_pkg::*;

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##2 out_strobe)
    else $error("transfer without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2))
    else $error("result without transfer");

  a_error_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.status != STS_OK |-> out_data.word_out == '0)
    else $error("word set on error");

  a_reset_quiet: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_strobe)
    else $error("result right after reset");

endmodule

bind timecode_packed_word_codec tpwc_checker u_tpwc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_data   (out_data),
  .out_strobe (out_strobe)
);
